// File: rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// shared types and constants of the sign partition interleave block
// ----------------------------------------------------------------------------
package spi_pkg;

  // entries of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // classification that travels with each word
  typedef struct packed {
    logic neg;
    logic last;
  } item_flags_t;

  // back status seen by the top level
  typedef struct packed {
    logic emitting;
    logic full;
    logic dropped;
  } back_status_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } back_state_e;

endpackage

// File: rtl/spi_in_if.sv
// ----------------------------------------------------------------------------
// spi_in_if
// input channel: one sample word and its end of batch mark
// ----------------------------------------------------------------------------
interface spi_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         final_item;

  modport source (output valid, sample, final_item, input ready);
  modport sink   (input valid, sample, final_item, output ready);
endinterface

// File: rtl/spi_out_if.sv
// ----------------------------------------------------------------------------
// spi_out_if
// output channel: one rearranged sample word with batch status
// ----------------------------------------------------------------------------
interface spi_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_out;
  logic                         batch_end;
  logic                         overflowed;

  modport source (output valid, sample_out, batch_end, overflowed, input ready);
  modport sink   (input valid, sample_out, batch_end, overflowed, output ready);
endinterface

// File: rtl/sign_partition_interleave_core.sv
// ----------------------------------------------------------------------------
// sign_partition_interleave_core
// stable sign partition of a batch with alternating merge on playback
// ----------------------------------------------------------------------------
// loading takes one word per cycle through the front register and two-entry queue
// first result follows the final word through the front register, queue, back
// state and output register, then one result per cycle while the sink is ready
// (one buffer read per cycle); during playback only the front register and
// queue take words, three at most, then the input stalls
// reset clears counts, overflow flag and all valid bits; buffers are left as is
module sign_partition_interleave_core #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spi_in_if.sink    in_i,
  spi_out_if.source out_o
);

  localparam int unsigned FlagW = $bits(spi_pkg::item_flags_t);

  logic                  push_valid, push_ready;
  logic [DATA_WIDTH-1:0] push_sample;
  spi_pkg::item_flags_t  push_flags;
  logic                  pop_valid, pop_ready;
  logic [DATA_WIDTH-1:0] pop_sample;
  spi_pkg::item_flags_t  pop_flags;
  spi_pkg::back_status_t status;

  spi_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_sample_o (push_sample),
    .push_flags_o  (push_flags)
  );

  spi_queue #(
    .WIDTH (DATA_WIDTH + FlagW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_sample, push_flags}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   ({pop_sample, pop_flags})
  );

  spi_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_sample_i (pop_sample),
    .pop_flags_i  (pop_flags),
    .out_o        (out_o),
    .status_o     (status)
  );

  // the back never drains the queue during playback
  a_no_pop_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |-> !status.emitting)
    else $error("queue popped during playback");

  // playback starts only after the final word of a batch left the queue
  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.emitting) |-> $past(pop_valid && pop_ready && pop_flags.last))
    else $error("playback started without a final word");

  // playback ends with the batch end word sitting in the output register
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.emitting) |-> (out_o.valid && out_o.batch_end))
    else $error("playback ended without a batch end word");

  // a word arriving on a full batch marks the batch as overflowed
  a_drop_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && status.full) |=> status.dropped)
    else $error("dropped word not flagged");

endmodule

// File: rtl/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// accepts input words, registers them and tags each with its sign
// ----------------------------------------------------------------------------
module spi_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  spi_in_if.sink                  in_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output logic [DATA_WIDTH-1:0]   push_sample_o,
  output spi_pkg::item_flags_t    push_flags_o
);

  logic                  valid_q;
  logic [DATA_WIDTH-1:0] sample_q;
  spi_pkg::item_flags_t  flags_q;
  logic                  accept;

  assign in_i.ready    = !valid_q || push_ready_i;
  assign accept        = in_i.valid && in_i.ready;
  assign push_valid_o  = valid_q;
  assign push_sample_o = sample_q;
  assign push_flags_o  = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q      <= in_i.sample;
      flags_q.neg   <= in_i.sample[DATA_WIDTH-1];
      flags_q.last  <= in_i.final_item;
    end
  end

endmodule

// File: rtl/spi_queue.sv
// ----------------------------------------------------------------------------
// spi_queue
// short fifo that decouples the front from the back
// ----------------------------------------------------------------------------
module spi_queue #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned Depth = spi_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    res = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/spi_back.sv
// ----------------------------------------------------------------------------
// spi_back
// fills the two sign buffers and plays the batch out in alternating order
// ----------------------------------------------------------------------------
module spi_back #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  logic [DATA_WIDTH-1:0]   pop_sample_i,
  input  spi_pkg::item_flags_t    pop_flags_i,
  spi_out_if.source               out_o,
  output spi_pkg::back_status_t   status_o
);

  localparam int unsigned AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);

  logic [DATA_WIDTH-1:0] nn_mem [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] ng_mem [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] nn_rd_q, ng_rd_q;

  spi_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0] nn_cnt_q, nn_cnt_d, ng_cnt_q, ng_cnt_d;
  logic [CntW-1:0] p_q, p_d, q_q, q_d;
  logic            odd_q, odd_d;
  logic            drop_q, drop_d;
  logic            out_valid_q, out_valid_d;
  logic            sel_ng_q, end_q, ovf_q;

  logic [CntW-1:0] total;
  logic            full, pop, nn_we, ng_we;
  logic            rem_nn, rem_ng, take_nn, issue, last_pick;

  assign total   = nn_cnt_q + ng_cnt_q;
  assign full    = total == CntW'(MAX_ITEMS);
  assign pop_ready_o = state_q == spi_pkg::ST_LOAD;
  assign pop     = pop_valid_i && pop_ready_o;
  assign nn_we   = pop && !full && !pop_flags_i.neg;
  assign ng_we   = pop && !full && pop_flags_i.neg;

  // alternate while both buffers hold words, then drain whichever remains
  assign rem_nn    = p_q < nn_cnt_q;
  assign rem_ng    = q_q < ng_cnt_q;
  assign take_nn   = rem_nn && (!rem_ng || !odd_q);
  assign issue     = (state_q == spi_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
  assign last_pick = (p_q + q_q + CntW'(1)) == total;

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sel_ng_q ? ng_rd_q : nn_rd_q;
  assign out_o.batch_end  = end_q;
  assign out_o.overflowed = ovf_q;

  assign status_o.emitting = state_q == spi_pkg::ST_EMIT;
  assign status_o.full     = full;
  assign status_o.dropped  = drop_q;

  always_comb begin
    state_d     = state_q;
    nn_cnt_d    = nn_cnt_q;
    ng_cnt_d    = ng_cnt_q;
    p_d         = p_q;
    q_d         = q_q;
    odd_d       = odd_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    unique case (state_q)
      spi_pkg::ST_LOAD: begin
        if (pop) begin
          if (full) drop_d = 1'b1;
          if (nn_we) nn_cnt_d = nn_cnt_q + CntW'(1);
          if (ng_we) ng_cnt_d = ng_cnt_q + CntW'(1);
          if (pop_flags_i.last) begin
            state_d = spi_pkg::ST_EMIT;
            p_d     = '0;
            q_d     = '0;
            odd_d   = 1'b0;
          end
        end
      end
      spi_pkg::ST_EMIT: begin
        if (issue) begin
          out_valid_d = 1'b1;
          odd_d       = !odd_q;
          if (take_nn) p_d = p_q + CntW'(1);
          else         q_d = q_q + CntW'(1);
          if (last_pick) begin
            state_d  = spi_pkg::ST_LOAD;
            nn_cnt_d = '0;
            ng_cnt_d = '0;
            drop_d   = 1'b0;
          end
        end
      end
      default: state_d = spi_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spi_pkg::ST_LOAD;
      nn_cnt_q    <= '0;
      ng_cnt_q    <= '0;
      p_q         <= '0;
      q_q         <= '0;
      odd_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nn_cnt_q    <= nn_cnt_d;
      ng_cnt_q    <= ng_cnt_d;
      p_q         <= p_d;
      q_q         <= q_d;
      odd_q       <= odd_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word metadata, loaded together with the buffer read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      sel_ng_q <= !take_nn;
      end_q    <= last_pick;
      ovf_q    <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nn_we) nn_mem[nn_cnt_q[AddrW-1:0]] <= pop_sample_i;
    if (issue && take_nn) nn_rd_q <= nn_mem[p_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ng_we) ng_mem[ng_cnt_q[AddrW-1:0]] <= pop_sample_i;
    if (issue && !take_nn) ng_rd_q <= ng_mem[q_q[AddrW-1:0]];
  end

endmodule

// File: test/sign_partition_interleave_core_tb.sv
// ----------------------------------------------------------------------------
// sign_partition_interleave_core_tb
// checks the sign partition and alternating merge against a queue predictor
// ----------------------------------------------------------------------------
// every accepted input word goes into a predictor that keeps its own
// non-negative and negative buffers, and the expected merged words of a batch
// are queued when its final word is taken. every accepted output word is
// compared field by field with the oldest expectation. the stimulus is a
// directed set of small batches and then random batches: mostly short, and
// one over capacity that fills the batch exactly and then drops its tail. the
// sender idles in bursts, and the receiver stalls on its own pattern and holds
// off once for a long stretch.
module sign_partition_interleave_core_tb;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned MaxItems  = 64;
  localparam int unsigned RandWords = 110;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [DataWidth-1:0] word;
    logic                 batch_end;
    logic                 overflowed;
  } merged_word_t;

  class partition_merge_board;
    logic [DataWidth-1:0] nonneg_q[$];
    logic [DataWidth-1:0] neg_q[$];
    bit                   dropped;
    merged_word_t         merged_q[$];
    int unsigned          failures;
    int unsigned          matched;
    int unsigned          words_in;
    int unsigned          batches;
    int unsigned          overflow_batches;

    // store or drop one word; on a final word queue the merged batch
    function void note_sample(logic [DataWidth-1:0] sample, logic final_item);
      int unsigned  total;
      int unsigned  k;
      merged_word_t item;
      words_in++;
      if (nonneg_q.size() + neg_q.size() < MaxItems) begin
        if (sample[DataWidth-1]) neg_q = {neg_q, sample};
        else nonneg_q = {nonneg_q, sample};
      end else begin
        dropped = 1'b1;
      end
      if (!final_item) return;
      batches++;
      if (dropped) overflow_batches++;
      total = nonneg_q.size() + neg_q.size();
      k = 0;
      while (nonneg_q.size() + neg_q.size() != 0) begin
        // alternate while both hold words, then drain whichever is left
        if (neg_q.size() == 0 || (nonneg_q.size() != 0 && k % 2 == 0))
          item.word = nonneg_q.pop_front();
        else
          item.word = neg_q.pop_front();
        item.batch_end  = (k + 1 == total);
        item.overflowed = dropped;
        merged_q = {merged_q, item};
        k++;
      end
      dropped = 1'b0;
    endfunction

    function void check_result(merged_word_t got);
      merged_word_t want;
      if (merged_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected word: sample_out %h batch_end %b overflowed %b",
                   got.word, got.batch_end, got.overflowed);
        return;
      end
      want = merged_q.pop_front();
      if (got.word !== want.word || got.batch_end !== want.batch_end ||
          got.overflowed !== want.overflowed) begin
        failures++;
        if (failures <= MaxReports)
          $display("mismatch: expected %h/%b/%b got %h/%b/%b (sample_out/batch_end/overflowed)",
                   want.word, want.batch_end, want.overflowed,
                   got.word, got.batch_end, got.overflowed);
      end else begin
        matched++;
      end
    endfunction

    function int unsigned pending();
      return merged_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  spi_in_if  #(.DATA_WIDTH(DataWidth)) in_if ();
  spi_out_if #(.DATA_WIDTH(DataWidth)) out_if ();

  sign_partition_interleave_core #(
    .MAX_ITEMS (MaxItems),
    .DATA_WIDTH(DataWidth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  partition_merge_board board = new();
  int unsigned burst_left;
  int unsigned words_sent;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("timeout after %0d checked words, %0d still expected",
             board.matched, board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // accepted words, sampled before the edge updates land
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_sample(in_if.sample, in_if.final_item);
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_result({out_if.sample_out, out_if.batch_end, out_if.overflowed});
  end

  // receiver: phases of a repeating ready pattern, plus one long hold-off
  initial begin : sink_stall
    logic [7:0]  pattern;
    int unsigned phase_left;
    int unsigned bit_idx;
    out_if.ready <= 1'b0;
    phase_left = 0;
    bit_idx    = 0;
    pattern    = 8'hff;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && board.matched >= 20) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        pattern    = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom_range(1, 255));
        phase_left = $urandom_range(8, 60);
      end
      out_if.ready <= pattern[bit_idx % 8];
      bit_idx++;
      phase_left--;
    end
  end

  task automatic send_word(input logic [DataWidth-1:0] sample, input logic final_item);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.sample     <= sample;
    in_if.final_item <= final_item;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  function automatic logic [DataWidth-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DataWidth-1){1'b0}}};
      1: return {1'b0, {(DataWidth-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return DataWidth'($urandom_range(0, 15));
      5: return -DataWidth'($urandom_range(1, 16));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_batch(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(pick_sample(), i == n - 1);
  endtask

  task automatic send_small_until(input int unsigned target);
    while (words_sent < target) send_batch($urandom_range(1, 9));
  endtask

  initial begin : stimulus
    int unsigned base;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.sample     <= '0;
    in_if.final_item <= 1'b0;
    burst_left = 0;
    words_sent = 0;
    hold_done  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of both signs, single-word batches, one-sign batches
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'hffff_fffe, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'hc000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    // negative tail longer than the non-negative side
    send_word(32'haaaa_aaaa, 1'b0);
    send_word(32'h0000_0007, 1'b0);
    send_word(32'hffff_ff00, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);

    // random: short batches around one batch that runs past capacity
    base = words_sent;
    send_small_until(base + 20);
    send_batch($urandom_range(MaxItems + 1, MaxItems + 4));
    send_small_until(base + RandWords);
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d words in %0d batches sent, %0d of them over capacity",
             board.words_in, board.batches, board.overflow_batches);
    $display("%0d merged words checked, %0d failures", board.matched, board.failures);
    if (board.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
